// ----- design/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam logic [7:0]  PREAMBLE_BYTE    = 8'hFE;
  localparam logic [7:0]  END_BYTE         = 8'hFD;
  localparam logic [15:0] SIZE_LIMIT_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_SIZE_LO = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_END     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_GOOD = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic [15:0] size;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   left_zero;
  } status_t;

endpackage

// ----- design/length_prefixed_frame_deframer.sv -----
// Top level of the length-prefixed frame deframer.
//
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per
// transaction. The block hunts for two 0xFE bytes, then passes on the command
// byte and each payload byte as result transactions on the output channel
// (out_valid, out_ready, out_byte, item_kind, frame_size), and closes each
// frame with a good or bad verdict transaction. The receiver drops bad frames.
// The size limit register is written through cfg_write_en and cfg_write_data by
// the user, only while the block is idle; the block itself does not enforce it.
// A result is registered as the byte that causes it is accepted. One byte is
// accepted every cycle while in_ready is high; the state update and the result
// come from one pass of logic between the parser state and the output register.
// When the receiver stalls, an output register and a skid stage hold up to two
// results; in_ready falls only when both are full and rises again the cycle
// after one is taken.
// Reset puts the parser into the preamble hunt, sets the size limit to 65535
// and empties the output stages.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  item_kind,
  output logic [15:0] frame_size
);
  import lpfd_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t head;
  status_t stat;

  assign in_accept = in_valid && in_ready;

  lpfd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .rx_byte       (rx_byte),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .res_valid     (res_valid),
    .res           (res),
    .stat          (stat)
  );

  lpfd_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept && res_valid),
    .push_data(res),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (head)
  );

  assign out_byte   = head.data;
  assign item_kind  = head.kind;
  assign frame_size = head.size;

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    stat.phase == PH_PAYLOAD |-> !stat.left_zero)
    else $error("payload phase with no bytes left");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    in_accept && res_valid |=> out_valid)
    else $error("accepted result not presented on output");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output register is empty");

endmodule

// ----- design/lpfd_parser.sv -----
// Frame parser state machine with the size limit register.
`timescale 1ns / 1ps

module lpfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_write_en,
  input  logic [15:0]       cfg_write_data,
  output logic              res_valid,
  output lpfd_pkg::result_t res,
  output lpfd_pkg::status_t stat
);
  import lpfd_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] declared_size;
  logic [15:0] declared_size_next;
  logic [15:0] bytes_left;
  logic [15:0] bytes_left_next;
  logic [15:0] size_limit;
  logic [15:0] size_full;

  assign size_full = {declared_size[15:8], rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      declared_size <= '0;
      bytes_left    <= '0;
      size_limit    <= SIZE_LIMIT_RESET;
    end else begin
      if (in_accept) begin
        phase         <= phase_next;
        declared_size <= declared_size_next;
        bytes_left    <= bytes_left_next;
      end
      if (cfg_write_en) begin
        size_limit <= cfg_write_data;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    declared_size_next = declared_size;
    bytes_left_next    = bytes_left;
    case (phase)
      PH_HUNT2: begin
        phase_next = (rx_byte == PREAMBLE_BYTE) ? PH_CMD : PH_HUNT1;
      end
      PH_CMD: begin
        phase_next = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        declared_size_next = {rx_byte, 8'h00};
        phase_next         = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        declared_size_next = size_full;
        if (size_full > size_limit) begin
          phase_next      = PH_HUNT1;
          bytes_left_next = '0;
        end else begin
          bytes_left_next = size_full;
          phase_next      = (size_full == '0) ? PH_END : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left == 16'd1) begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        phase_next = PH_HUNT1;
      end
      default: begin
        phase_next = (rx_byte == PREAMBLE_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res.data  = '0;
    res.kind  = KIND_CMD;
    res.size  = '0;
    case (phase)
      PH_CMD: begin
        res_valid = 1'b1;
        res.data  = rx_byte;
      end
      PH_SIZE_LO: begin
        if (size_full > size_limit) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD;
          res.size  = size_full;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.data  = rx_byte;
        res.kind  = KIND_DATA;
        res.size  = declared_size;
      end
      PH_END: begin
        res_valid = 1'b1;
        res.kind  = (rx_byte == END_BYTE) ? KIND_GOOD : KIND_BAD;
        res.size  = declared_size;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign stat.phase     = phase;
  assign stat.left_zero = (bytes_left == '0);

endmodule

// ----- design/lpfd_out_queue.sv -----
// Two-entry output register with skid stage for result transactions.
`timescale 1ns / 1ps

module lpfd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpfd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfd_pkg::result_t out_data
);
  import lpfd_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule
